FILE: src/sdbrrip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbrrip_pkg
// Shared types and constants for the dead-block stream rrip replacement policy.
// ----------------------------------------------------------------------------
package sdbrrip_pkg;

  localparam int NUM_SETS_DEF    = 2048;
  localparam int NUM_WAYS_DEF    = 16;
  localparam int SIG_BITS_DEF    = 6;
  localparam int LEADER_SETS_DEF = 32;

  localparam int SET_W    = 11;
  localparam int WAY_W    = 4;
  localparam int MASK_W   = 16;
  localparam int ADDR_W   = 64;
  localparam int SCNT_W   = 3;
  localparam int RCNT_W   = 2;
  localparam int HB_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [SCNT_W-1:0] SCNT_MAX = 3'd7;
  localparam logic [RCNT_W-1:0] RCNT_MAX = 2'd3;
  localparam logic [1:0]        RRPV_FAR  = 2'd3;
  localparam logic [1:0]        RRPV_NEAR = 2'd1;
  localparam logic [1:0]        RRPV_HIT  = 2'd0;

  localparam logic [SCNT_W-1:0] STREAM_THR_RST = 3'd4;
  localparam logic [RCNT_W-1:0] REUSE_THR_RST  = 2'd2;
  localparam logic [HB_W-1:0]   PERIOD_RST     = 20'd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STREAM_THR = 2'd0,
    CFG_REUSE_THR  = 2'd1,
    CFG_PERIOD     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_VICTIM = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_DEC,
    ST_RESULT,
    ST_DEAD
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic dec;
    logic sweep;
    logic sweep_all;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] in_cmd;
    logic       way_ok;
    logic       tick_clear;
    logic       req_query;
    logic       req_miss;
    logic       sweep_last;
    logic       out_free;
  } stat_t;

endpackage

FILE: src/sdbrrip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbrrip_ctrl
// Sequencer for request execution, result hand-off and memory sweeps.
// ----------------------------------------------------------------------------
module sdbrrip_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  sdbrrip_pkg::stat_t   stat_i,
  output sdbrrip_pkg::ctrl_t   ctrl_o
);

  sdbrrip_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdbrrip_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    ctrl_o        = '0;
    case (state_q)
      sdbrrip_pkg::ST_INIT: begin
        ctrl_o.sweep     = 1'b1;
        ctrl_o.sweep_all = 1'b1;
        if (stat_i.sweep_last) state_d = sdbrrip_pkg::ST_IDLE;
      end
      sdbrrip_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctrl_o.accept = s_axis_tvalid;
        if (s_axis_tvalid) begin
          case (stat_i.in_cmd)
            sdbrrip_pkg::CMD_VICTIM: state_d = sdbrrip_pkg::ST_EXEC;
            sdbrrip_pkg::CMD_UPDATE: begin
              if (stat_i.way_ok) state_d = sdbrrip_pkg::ST_EXEC;
            end
            sdbrrip_pkg::CMD_TICK: begin
              if (stat_i.tick_clear) state_d = sdbrrip_pkg::ST_DEAD;
            end
            default: state_d = sdbrrip_pkg::ST_IDLE;
          endcase
        end
      end
      sdbrrip_pkg::ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        if (stat_i.req_query) state_d = sdbrrip_pkg::ST_RESULT;
        else if (stat_i.req_miss) state_d = sdbrrip_pkg::ST_DEC;
        else state_d = sdbrrip_pkg::ST_IDLE;
      end
      sdbrrip_pkg::ST_DEC: begin
        ctrl_o.dec = 1'b1;
        state_d    = sdbrrip_pkg::ST_IDLE;
      end
      sdbrrip_pkg::ST_RESULT: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = sdbrrip_pkg::ST_IDLE;
        end
      end
      sdbrrip_pkg::ST_DEAD: begin
        ctrl_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = sdbrrip_pkg::ST_IDLE;
      end
      default: state_d = sdbrrip_pkg::ST_INIT;
    endcase
  end

endmodule

FILE: src/sdbrrip_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbrrip_dp
// Set memories, reuse counters, stride detectors, victim and insertion logic.
// ----------------------------------------------------------------------------
module sdbrrip_dp #(
  parameter int NUM_SETS    = sdbrrip_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS    = sdbrrip_pkg::NUM_WAYS_DEF,
  parameter int SIG_BITS    = sdbrrip_pkg::SIG_BITS_DEF,
  parameter int LEADER_SETS = sdbrrip_pkg::LEADER_SETS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sdbrrip_pkg::ctrl_t                  ctrl_i,
  output sdbrrip_pkg::stat_t                  stat_o,
  input  logic [1:0]                          in_cmd_i,
  input  logic                                in_hit_i,
  input  logic [sdbrrip_pkg::SET_W-1:0]       in_set_i,
  input  logic [sdbrrip_pkg::WAY_W-1:0]       in_way_i,
  input  logic [sdbrrip_pkg::MASK_W-1:0]      in_mask_i,
  input  logic [sdbrrip_pkg::ADDR_W-1:0]      in_pc_i,
  input  logic [sdbrrip_pkg::ADDR_W-1:0]      in_paddr_i,
  input  logic                                cfg_we_i,
  input  logic [sdbrrip_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sdbrrip_pkg::HB_W-1:0]        cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [sdbrrip_pkg::WAY_W-1:0]       out_way_o
);

  localparam int ROW_W  = $clog2(NUM_SETS);
  localparam int SX     = (ROW_W > sdbrrip_pkg::SET_W) ? ROW_W : sdbrrip_pkg::SET_W;
  localparam int LW     = (LEADER_SETS > 1) ? $clog2(LEADER_SETS) : 1;
  localparam int CNT_N  = 1 << SIG_BITS;
  localparam int RW     = 2 + SIG_BITS;
  localparam int WW     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int MW     = (NUM_WAYS < sdbrrip_pkg::MASK_W) ? NUM_WAYS : sdbrrip_pkg::MASK_W;
  localparam int SL0    = (NUM_SETS > LEADER_SETS) ? NUM_SETS : LEADER_SETS;
  localparam int SW_LEN = (SL0 > CNT_N) ? SL0 : CNT_N;
  localparam int SW_W   = $clog2(SW_LEN);
  localparam int STR_W  = 2 * sdbrrip_pkg::ADDR_W + sdbrrip_pkg::SCNT_W;

  // memories
  logic [NUM_WAYS*RW-1:0]           row_mem  [NUM_SETS];
  logic [NUM_WAYS-1:0]              dead_mem [NUM_SETS];
  logic [STR_W-1:0]                 str_mem  [LEADER_SETS];
  logic [sdbrrip_pkg::RCNT_W-1:0]   rcnt_mem [CNT_N];

  logic [NUM_WAYS*RW-1:0]         row_rd_q;
  logic [NUM_WAYS-1:0]            dead_rd_q;
  logic [STR_W-1:0]               str_rd_q;
  logic [sdbrrip_pkg::RCNT_W-1:0] rcnt_rd_q;

  // configuration
  logic [sdbrrip_pkg::SCNT_W-1:0] stream_thr_q;
  logic [sdbrrip_pkg::RCNT_W-1:0] reuse_thr_q;
  logic [sdbrrip_pkg::HB_W-1:0]   period_q;
  logic [sdbrrip_pkg::HB_W-1:0]   hb_q, hb_next;
  logic                           hb_clear;

  // captured request
  logic [1:0]           cmd_q;
  logic                 hit_q;
  logic [ROW_W-1:0]     row_q;
  logic                 lead_q;
  logic [LW-1:0]        lidx_q;
  logic [WW-1:0]        way_q;
  logic [MW-1:0]        mask_q;
  logic [SIG_BITS-1:0]  sig_q;
  logic [SIG_BITS-1:0]  old_sig_q;
  logic [sdbrrip_pkg::ADDR_W-1:0] paddr_q;

  logic [SW_W-1:0] sw_q;
  logic            out_valid_q;
  logic [sdbrrip_pkg::WAY_W-1:0] out_way_q, victim_q;

  // input decode
  logic [SX-1:0]       set_x, row_x;
  logic [ROW_W-1:0]    in_row;
  logic                in_lead;
  logic [LW-1:0]       in_lidx;
  logic [SIG_BITS-1:0] in_sig;

  assign set_x   = SX'(in_set_i);
  assign in_row  = set_x[ROW_W-1:0];
  assign row_x   = SX'(in_row);
  assign in_lead = 32'(in_row) < LEADER_SETS;
  assign in_lidx = row_x[LW-1:0];
  assign in_sig  = in_pc_i[SIG_BITS-1:0] ^ in_pc_i[6 +: SIG_BITS] ^ in_pc_i[12 +: SIG_BITS];

  assign hb_next  = hb_q + 1'b1;
  assign hb_clear = hb_next >= period_q;

  // way fields of the captured row
  logic [1:0]          rrpv_a [NUM_WAYS];
  logic [SIG_BITS-1:0] sig_a  [NUM_WAYS];
  logic [1:0]          aged_a [NUM_WAYS];
  logic [1:0]          top, add;
  logic                any_hi, any_lo;
  logic [NUM_WAYS*RW-1:0] aged_row, upd_row;
  logic [NUM_WAYS-1:0]    upd_dead;
  logic [sdbrrip_pkg::WAY_W-1:0] pick_inv, pick_old;
  logic                   has_inv;

  always_comb begin
    any_hi = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrpv_a[w] = row_rd_q[w*RW +: 2];
      sig_a[w]  = row_rd_q[w*RW+2 +: SIG_BITS];
      any_hi    = any_hi | rrpv_a[w][1];
    end
    any_lo = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any_lo = any_lo | (rrpv_a[w][0] & (rrpv_a[w][1] == any_hi));
    end
    top = {any_hi, any_lo};
    add = sdbrrip_pkg::RRPV_FAR - top;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_a[w]             = rrpv_a[w] + add;
      aged_row[w*RW +: 2]   = aged_a[w];
      aged_row[w*RW+2 +: SIG_BITS] = sig_a[w];
    end
    has_inv  = 1'b0;
    pick_inv = '0;
    for (int w = MW - 1; w >= 0; w--) begin
      if (!mask_q[w]) begin
        has_inv  = 1'b1;
        pick_inv = sdbrrip_pkg::WAY_W'(w);
      end
    end
    pick_old = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged_a[w] == sdbrrip_pkg::RRPV_FAR) pick_old = sdbrrip_pkg::WAY_W'(w);
    end
  end

  // stride detection and insertion
  logic [sdbrrip_pkg::ADDR_W-1:0] s_addr, s_stride, stride;
  logic [sdbrrip_pkg::SCNT_W-1:0] s_cnt, n_cnt;
  logic                           streaming;
  logic [1:0]                     new_rrpv;
  logic                           dead_old;

  assign s_addr   = str_rd_q[0 +: sdbrrip_pkg::ADDR_W];
  assign s_stride = str_rd_q[sdbrrip_pkg::ADDR_W +: sdbrrip_pkg::ADDR_W];
  assign s_cnt    = str_rd_q[2*sdbrrip_pkg::ADDR_W +: sdbrrip_pkg::SCNT_W];
  assign stride   = paddr_q - s_addr;
  assign dead_old = dead_rd_q[way_q];

  always_comb begin
    if (s_stride != '0 && stride == s_stride) begin
      n_cnt = (s_cnt < sdbrrip_pkg::SCNT_MAX) ? s_cnt + 1'b1 : s_cnt;
    end else begin
      n_cnt = '0;
    end
    streaming = lead_q && (n_cnt >= stream_thr_q);
    if (hit_q) new_rrpv = sdbrrip_pkg::RRPV_HIT;
    else if (streaming) new_rrpv = sdbrrip_pkg::RRPV_FAR;
    else if (rcnt_rd_q >= reuse_thr_q || !dead_old) new_rrpv = sdbrrip_pkg::RRPV_NEAR;
    else new_rrpv = sdbrrip_pkg::RRPV_FAR;
    upd_row  = row_rd_q;
    upd_dead = dead_rd_q;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WW'(w) == way_q) begin
        upd_row[w*RW +: 2]          = new_rrpv;
        upd_row[w*RW+2 +: SIG_BITS] = sig_q;
        upd_dead[w]                 = !hit_q;
      end
    end
  end

  logic is_query, is_update, sw_all;
  assign is_query  = cmd_q == sdbrrip_pkg::CMD_VICTIM;
  assign is_update = cmd_q == sdbrrip_pkg::CMD_UPDATE;
  assign sw_all    = ctrl_i.sweep_all;

  // row, dead and stride memories
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      row_rd_q  <= row_mem[in_row];
      dead_rd_q <= dead_mem[in_row];
      str_rd_q  <= str_mem[in_lidx];
    end
    if (ctrl_i.sweep) begin
      if (32'(sw_q) < NUM_SETS) begin
        dead_mem[sw_q[ROW_W-1:0]] <= '0;
        if (sw_all) row_mem[sw_q[ROW_W-1:0]] <= '0;
      end
      if (sw_all && 32'(sw_q) < LEADER_SETS) str_mem[sw_q[LW-1:0]] <= '0;
    end else if (ctrl_i.exec) begin
      if (is_query) begin
        if (!has_inv && top != sdbrrip_pkg::RRPV_FAR) row_mem[row_q] <= aged_row;
      end else if (is_update) begin
        row_mem[row_q]  <= upd_row;
        dead_mem[row_q] <= upd_dead;
        if (lead_q) str_mem[lidx_q] <= {n_cnt, stride, paddr_q};
      end
    end
  end

  // reuse counters
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) rcnt_rd_q <= rcnt_mem[in_sig];
    else if (ctrl_i.exec) rcnt_rd_q <= rcnt_mem[sig_a[way_q]];
    if (ctrl_i.sweep && sw_all && 32'(sw_q) < CNT_N) begin
      rcnt_mem[sw_q[SIG_BITS-1:0]] <= '0;
    end else if (ctrl_i.exec && is_update && hit_q) begin
      if (rcnt_rd_q < sdbrrip_pkg::RCNT_MAX) rcnt_mem[sig_q] <= rcnt_rd_q + 1'b1;
    end else if (ctrl_i.dec) begin
      if (rcnt_rd_q != '0) rcnt_mem[old_sig_q] <= rcnt_rd_q - 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      hit_q   <= in_hit_i;
      row_q   <= in_row;
      lead_q  <= in_lead;
      lidx_q  <= in_lidx;
      way_q   <= WW'(in_way_i);
      mask_q  <= in_mask_i[MW-1:0];
      sig_q   <= in_sig;
      paddr_q <= in_paddr_i;
    end
    if (ctrl_i.exec) begin
      old_sig_q <= sig_a[way_q];
      victim_q  <= has_inv ? pick_inv : pick_old;
    end
    if (ctrl_i.out_load) out_way_q <= victim_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= sdbrrip_pkg::CMD_TICK;
      sw_q         <= '0;
      hb_q         <= '0;
      out_valid_q  <= 1'b0;
      stream_thr_q <= sdbrrip_pkg::STREAM_THR_RST;
      reuse_thr_q  <= sdbrrip_pkg::REUSE_THR_RST;
      period_q     <= sdbrrip_pkg::PERIOD_RST;
    end else begin
      if (ctrl_i.accept) cmd_q <= in_cmd_i;
      sw_q <= ctrl_i.sweep ? sw_q + 1'b1 : '0;
      if (ctrl_i.accept && in_cmd_i == sdbrrip_pkg::CMD_TICK) begin
        hb_q <= hb_clear ? '0 : hb_next;
      end
      if (ctrl_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          sdbrrip_pkg::CFG_STREAM_THR: stream_thr_q <= cfg_data_i[sdbrrip_pkg::SCNT_W-1:0];
          sdbrrip_pkg::CFG_REUSE_THR:  reuse_thr_q  <= cfg_data_i[sdbrrip_pkg::RCNT_W-1:0];
          sdbrrip_pkg::CFG_PERIOD:     period_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign stat_o.in_cmd     = in_cmd_i;
  assign stat_o.way_ok     = 32'(in_way_i) < NUM_WAYS;
  assign stat_o.tick_clear = hb_clear;
  assign stat_o.req_query  = is_query;
  assign stat_o.req_miss   = is_update && !hit_q;
  assign stat_o.sweep_last = sw_q == (sw_all ? SW_W'(SW_LEN - 1) : SW_W'(NUM_SETS - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_way_o   = out_way_q;

endmodule

FILE: src/ship_dead_block_stream_rrip_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ship_dead_block_stream_rrip_policy
// Signature-based rrip replacement with dead flags and leader-set stride
// detection; victim queries, access updates and heartbeat ticks.
// ----------------------------------------------------------------------------
// a victim query runs through EXEC and RESULT to the output register; an update
//   runs EXEC on a hit, EXEC and DEC on a fill (extra reuse counter update); a tick
//   that does not clear dead flags stays in IDLE. A new request is taken only in
//   IDLE; a finished query holds in RESULT while the output register is full
// tick that clears dead flags: a sweep over all NUM_SETS sets in DEAD, no requests taken
// reset: a clearing sweep of the row, dead, stride and reuse counter memories in INIT
module ship_dead_block_stream_rrip_policy #(
  parameter int NUM_SETS    = sdbrrip_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS    = sdbrrip_pkg::NUM_WAYS_DEF,
  parameter int SIG_BITS    = sdbrrip_pkg::SIG_BITS_DEF,
  parameter int LEADER_SETS = sdbrrip_pkg::LEADER_SETS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // set_index, way_index, valid_mask, pc, paddr, pad
  input  logic [159:0] s_axis_tdata,
  // cmd, hit
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // victim_way, pad
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [sdbrrip_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sdbrrip_pkg::HB_W-1:0]      cfg_data_i
);

  sdbrrip_pkg::ctrl_t ctrl;
  sdbrrip_pkg::stat_t stat;
  logic [sdbrrip_pkg::WAY_W-1:0] out_way;

  assign cfg_ready_o = 1'b1;

  sdbrrip_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .ctrl_o        (ctrl)
  );

  sdbrrip_dp #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .SIG_BITS    (SIG_BITS),
    .LEADER_SETS (LEADER_SETS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_cmd_i    (s_axis_tuser[1:0]),
    .in_hit_i    (s_axis_tuser[2]),
    .in_set_i    (s_axis_tdata[10:0]),
    .in_way_i    (s_axis_tdata[14:11]),
    .in_mask_i   (s_axis_tdata[30:15]),
    .in_pc_i     (s_axis_tdata[94:31]),
    .in_paddr_i  (s_axis_tdata[158:95]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_way_o   (out_way)
  );

  assign m_axis_tdata = {4'b0000, out_way};

endmodule

FILE: src/sdbrrip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbrrip_checker
// Port-level properties of the replacement policy, bound to the top level.
// ----------------------------------------------------------------------------
module sdbrrip_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [2:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == sdbrrip_pkg::CMD_VICTIM
    |=> !s_axis_tready)
    else $error("request taken right after a victim query");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a request in flight");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:4] == 4'b0000)
    else $error("result padding not zero");

endmodule

bind ship_dead_block_stream_rrip_policy sdbrrip_checker u_sdbrrip_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
